/* rtl/sam_pkg.sv */
// ----------------------------------------------------------------------------
// sam_pkg: shared types and constants of the stack allocator
// Request and result items, table entries, cell controls, status codes.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int unsigned SAM_MAX_BLOCKS = 32;

  // function codes
  localparam logic [2:0] FN_ALLOC_FIX  = 3'd0;
  localparam logic [2:0] FN_ALLOC_MOV  = 3'd1;
  localparam logic [2:0] FN_FREE_FIX   = 3'd2;
  localparam logic [2:0] FN_FREE_MOV   = 3'd3;
  localparam logic [2:0] FN_RESIZE_FIX = 3'd4;
  localparam logic [2:0] FN_RESIZE_MOV = 3'd5;

  // configuration register indexes
  localparam logic REG_TOTAL_BYTES  = 1'b0;
  localparam logic REG_BASE_ADDRESS = 1'b1;

  localparam logic KIND_RELOC = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_OOM          = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_NOT_LAST     = 3'd4,
    ST_NOT_FOUND    = 3'd5,
    ST_FIXED_BEHIND = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_WRITE,
    ACT_POP,
    ACT_REMOVE
  } act_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] block_addr;
    logic [31:0] req_bytes;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [31:0] new_addr;
    logic [31:0] old_addr;
    logic [31:0] free_bytes;
    logic [31:0] used_bytes;
    logic [31:0] peak_bytes;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        movable;
  } entry_t;

  function automatic logic [31:0] free_now(input logic [31:0] total,
                                           input logic [31:0] used);
    logic [31:0] t;
    t = {total[31:6], 6'b0};
    return (t > used) ? (t - used) : 32'd0;
  endfunction

endpackage

/* rtl/sam_cell.sv */
// ----------------------------------------------------------------------------
// sam_cell: one entry of the block table
// Holds one block record; takes its neighbor's record, loads a new one or holds.
// ----------------------------------------------------------------------------
module sam_cell import sam_pkg::*; (
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  entry_t   nbr_i,
  input  entry_t   load_i,
  output entry_t   entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      CELL_SHIFT: entry_q <= nbr_i;
      CELL_LOAD:  entry_q <= load_i;
      default:    entry_q <= entry_q;
    endcase
  end

  assign entry_o = entry_q;

endmodule

/* rtl/stack_allocator_with_movable_blocks.sv */
// ----------------------------------------------------------------------------
// stack_allocator_with_movable_blocks: stack arena allocator with compaction
// Keeps the block table in a ring of cells and walks it one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request on req_i with start while busy is low. Results come
//   out on res_o, each marked by res_valid_o for one cycle: zero or more
//   relocation items (one per moved block) and then one final item with
//   last set. The receiver cannot stall; every result is taken as shown.
//   Configuration (total_bytes, base_address) is written through cfg_*
//   while no request is in flight; cfg_ready_o is always high.
// Flow and throughput:
//   Allocation and unused codes: idle, evaluate, finish, then the final
//   item is registered. Free or resize: one lap of the cell ring to search,
//   plus a second lap when a movable block is freed or changes size, in
//   which the later blocks shift. The ring lap sets the rate: one table
//   entry passes the head cell per cycle. busy goes low as the final
//   item is shown.
// Reset: the table is empty and the counters are zero; total_bytes resets
//   to 0xFFFF_FFC0 (the 32-bit arena on the 64-byte grain), base_address to 0.
// ----------------------------------------------------------------------------
module stack_allocator_with_movable_blocks import sam_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = SAM_MAX_BLOCKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  state_e state_q, state_d;

  logic [IW-1:0] cnt_q;
  logic [CW-1:0] count_q;
  logic [31:0]   alloc_q, peak_q, total_q, base_q;
  logic [2:0]    func_q;
  logic [31:0]   addr_q;
  logic [32:0]   n_q;
  logic          found_q, fixed_after_q, last_hit_q;
  logic [IW-1:0] nr_q;
  entry_t        nr_ent_q, last_ent_q;
  status_e       status_q;
  act_e          act_q;
  logic [31:0]   delta_q, new_addr_q;
  logic [IW-1:0] widx_q;
  entry_t        wr_q;
  logic          res_valid_q;
  res_t          res_q;

  entry_t   cell_ent [MAX_BLOCKS];
  cell_op_e cell_op  [MAX_BLOCKS];
  entry_t   head, tail_in;

  logic          accept, lap_end, in_range, hit, shift_hit;
  logic [32:0]   n_in, sum_in;
  logic [31:0]   fr, peak_new;
  logic [32:0]   fr33;
  status_e       ev_status;
  act_e          ev_act;
  logic [31:0]   ev_alloc, ev_delta, ev_new_addr;
  logic [IW-1:0] ev_widx;
  entry_t        ev_wr;
  logic          ev_shift;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign lap_end     = (cnt_q == IW'(MAX_BLOCKS - 1));

  // size rounding to the 64-byte grain, 64 at least
  assign sum_in = {1'b0, req_i.req_bytes} + 33'd63;
  assign n_in   = (sum_in[32:6] == 27'd0) ? 33'd64 : {sum_in[32:6], 6'b0};

  assign head      = cell_ent[0];
  assign in_range  = (CW'(cnt_q) < count_q);
  assign hit       = ((base_q + head.start) == addr_q);
  assign shift_hit = (state_q == S_SHIFT) && in_range && (cnt_q > nr_q);

  always_comb begin
    tail_in = head;
    if (shift_hit) begin
      tail_in.start = head.start + delta_q;
    end
  end

  // cell ring
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    entry_t nbr;
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign nbr = tail_in;
    end else begin : g_mid
      assign nbr = cell_ent[k+1];
    end

    always_comb begin
      cell_op[k] = CELL_HOLD;
      case (state_q)
        S_SCAN, S_SHIFT: cell_op[k] = CELL_SHIFT;
        S_FINISH: begin
          if (act_q == ACT_REMOVE && IW'(k) >= nr_q) begin
            cell_op[k] = CELL_SHIFT;
          end else if ((act_q == ACT_PUSH || act_q == ACT_WRITE) && IW'(k) == widx_q) begin
            cell_op[k] = CELL_LOAD;
          end
        end
        default: cell_op[k] = CELL_HOLD;
      endcase
    end

    sam_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[k]),
      .nbr_i   (nbr),
      .load_i  (wr_q),
      .entry_o (cell_ent[k])
    );
  end

  // decision in the evaluate state, after the search lap for free and resize
  assign fr   = free_now(total_q, alloc_q);
  assign fr33 = {1'b0, fr};

  always_comb begin
    ev_status   = ST_OK;
    ev_act      = ACT_NONE;
    ev_alloc    = alloc_q;
    ev_delta    = '0;
    ev_new_addr = '0;
    ev_widx     = nr_q;
    ev_wr       = '{start: nr_ent_q.start, size: n_q[31:0], movable: nr_ent_q.movable};
    case (func_q)
      FN_ALLOC_FIX, FN_ALLOC_MOV: begin
        if (count_q >= CW'(MAX_BLOCKS)) begin
          ev_status = ST_FULL;
        end else if (n_q > fr33) begin
          ev_status = ST_OOM;
        end else begin
          ev_act      = ACT_PUSH;
          ev_alloc    = alloc_q + n_q[31:0];
          ev_widx     = count_q[IW-1:0];
          ev_wr       = '{start: alloc_q, size: n_q[31:0],
                          movable: (func_q == FN_ALLOC_MOV)};
          ev_new_addr = base_q + alloc_q;
        end
      end
      FN_FREE_FIX, FN_RESIZE_FIX: begin
        if (count_q == '0) begin
          ev_status = ST_EMPTY;
        end else if (!last_hit_q) begin
          ev_status = ST_NOT_LAST;
        end else if (func_q == FN_FREE_FIX) begin
          ev_act   = ACT_POP;
          ev_alloc = alloc_q - last_ent_q.size;
        end else if (n_q > fr33 + {1'b0, last_ent_q.size}) begin
          ev_status = ST_OOM;
        end else begin
          ev_act      = ACT_WRITE;
          ev_alloc    = alloc_q - last_ent_q.size + n_q[31:0];
          ev_widx     = IW'(count_q - CW'(1));
          ev_wr       = '{start: last_ent_q.start, size: n_q[31:0],
                          movable: last_ent_q.movable};
          ev_new_addr = base_q + last_ent_q.start;
        end
      end
      FN_FREE_MOV, FN_RESIZE_MOV: begin
        if (count_q == '0) begin
          ev_status = ST_EMPTY;
        end else if (!found_q) begin
          ev_status = ST_NOT_FOUND;
        end else if (fixed_after_q) begin
          ev_status = ST_FIXED_BEHIND;
        end else if (func_q == FN_FREE_MOV) begin
          ev_act   = ACT_REMOVE;
          ev_alloc = alloc_q - nr_ent_q.size;
          ev_delta = 32'd0 - nr_ent_q.size;
        end else if (n_q > fr33 + {1'b0, nr_ent_q.size}) begin
          ev_status = ST_OOM;
        end else begin
          ev_act      = ACT_WRITE;
          ev_alloc    = alloc_q - nr_ent_q.size + n_q[31:0];
          ev_delta    = n_q[31:0] - nr_ent_q.size;
          ev_new_addr = base_q + nr_ent_q.start;
        end
      end
      default: ev_status = ST_OK;
    endcase
    ev_shift = (ev_status == ST_OK) && (ev_delta != '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.func == FN_FREE_FIX || req_i.func == FN_FREE_MOV ||
              req_i.func == FN_RESIZE_FIX || req_i.func == FN_RESIZE_MOV) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_SCAN:   if (lap_end) state_d = S_EVAL;
      S_EVAL:   state_d = ev_shift ? S_SHIFT : S_FINISH;
      S_SHIFT:  if (lap_end) state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      count_q <= '0;
      alloc_q <= '0;
      peak_q  <= '0;
      total_q <= 32'hFFFF_FFC0;
      base_q  <= '0;
      act_q   <= ACT_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TOTAL_BYTES:  total_q <= cfg_data_i;
          REG_BASE_ADDRESS: base_q  <= cfg_data_i;
          default:          total_q <= total_q;
        endcase
      end
      if (state_q == S_SCAN || state_q == S_SHIFT) begin
        cnt_q <= lap_end ? '0 : cnt_q + IW'(1);
      end
      if (state_q == S_EVAL) begin
        act_q   <= ev_act;
        alloc_q <= ev_alloc;
      end
      if (state_q == S_FINISH) begin
        peak_q <= peak_new;
        case (act_q)
          ACT_PUSH:            count_q <= count_q + CW'(1);
          ACT_POP, ACT_REMOVE: count_q <= count_q - CW'(1);
          default:             count_q <= count_q;
        endcase
      end
    end
  end

  // request, search results and decision
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q        <= req_i.func;
      addr_q        <= req_i.block_addr;
      n_q           <= n_in;
      found_q       <= 1'b0;
      fixed_after_q <= 1'b0;
      last_hit_q    <= 1'b0;
    end
    if (state_q == S_SCAN && in_range) begin
      // keep the highest match; track fixed blocks behind it
      if (hit) begin
        found_q       <= 1'b1;
        nr_q          <= cnt_q;
        nr_ent_q      <= head;
        fixed_after_q <= 1'b0;
      end else if (!head.movable) begin
        fixed_after_q <= 1'b1;
      end
      if (CW'(cnt_q) == count_q - CW'(1)) begin
        last_hit_q <= hit;
        last_ent_q <= head;
      end
    end
    if (state_q == S_EVAL) begin
      status_q   <= ev_status;
      delta_q    <= ev_delta;
      new_addr_q <= ev_new_addr;
      widx_q     <= ev_widx;
      wr_q       <= ev_wr;
    end
  end

  // results
  assign peak_new = (alloc_q > peak_q) ? alloc_q : peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= shift_hit || (state_q == S_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_hit) begin
      res_q.kind       <= KIND_RELOC;
      res_q.status     <= ST_OK;
      res_q.new_addr   <= base_q + tail_in.start;
      res_q.old_addr   <= base_q + head.start;
      res_q.free_bytes <= fr;
      res_q.used_bytes <= alloc_q;
      res_q.peak_bytes <= peak_q;
      res_q.last       <= 1'b0;
    end else if (state_q == S_FINISH) begin
      res_q.kind       <= KIND_FINAL;
      res_q.status     <= status_q;
      res_q.new_addr   <= new_addr_q;
      res_q.old_addr   <= '0;
      res_q.free_bytes <= fr;
      res_q.used_bytes <= alloc_q;
      res_q.peak_bytes <= peak_new;
      res_q.last       <= 1'b1;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
